/* hdl/sig_pkg.sv */
// sig_pkg: shared types and constants for the split information gain core
// no dependencies; imported by sig_log2 and split_information_gain_core
`default_nettype none

package sig_pkg;

	localparam int NUM_CLASSES_DEF  = 16;
	localparam int NUM_BRANCHES_DEF = 8;

	localparam int WEIGHT_W = 32;
	localparam int FRAC_W   = 16;
	localparam int MERIT_W  = 20;
	localparam int CNT_W    = 4;
	localparam int NUMER_W  = 64;

	localparam int MERIT_MAX = 524287;
	localparam int MERIT_MIN = -524288;

	localparam logic [CNT_W-1:0]  CNT_MAX      = 4'd15;
	localparam logic [FRAC_W-1:0] MIN_FRAC_RST = 16'd655;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic                mode;
		logic [2:0]          branch;
		logic [3:0]          class_index;
		logic                last;
	} item_t;

	typedef struct packed {
		logic signed [MERIT_W-1:0] merit;
		logic [CNT_W-1:0]          branches_above;
		logic                      empty_branches;
	} result_t;

endpackage

`default_nettype wire

/* hdl/sig_ram.sv */
// sig_ram: generic single write port, single read port ram with registered read
// no package dependencies
`default_nettype none

module sig_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 144
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hdl/sig_log2.sv */
// sig_log2: iterative log2 with 16 fractional bits (shift normalize, then squaring)
// depends on sig_pkg
`default_nettype none

module sig_log2
	import sig_pkg::*;
#(
	parameter int XW = 35
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [XW-1:0]                 x,
	output logic                               done,
	output logic [$clog2(XW)+FRAC_W-1:0]       result
);

	localparam int EW = $clog2(XW);
	localparam int KW = $clog2(FRAC_W);

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_NORM = 2'd1;
	localparam logic [1:0] L_SQR  = 2'd2;

	logic [1:0]          state_q;
	logic [XW-1:0]       x_q;
	logic [EW-1:0]       e_q;
	logic [31:0]         m_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [KW-1:0]       k_q;
	logic                done_q;
	logic [63:0]         sq;
	logic [32:0]         t;

	assign sq     = 64'(m_q) * 64'(m_q);
	assign t      = sq[63:31];
	assign done   = done_q;
	assign result = {e_q, frac_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= L_NORM;
					end
				end
				L_NORM: begin
					if (x_q[XW-1]) begin
						state_q <= L_SQR;
					end
				end
				L_SQR: begin
					if (k_q == KW'(FRAC_W-1)) begin
						state_q <= L_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE: begin
				if (start) begin
					x_q <= x;
					e_q <= EW'(XW-1);
				end
			end
			L_NORM: begin
				if (x_q[XW-1]) begin
					m_q    <= x_q[XW-1 -: 32];
					k_q    <= '0;
					frac_q <= '0;
				end else begin
					x_q <= {x_q[XW-2:0], 1'b0};
					e_q <= e_q - 1'b1;
				end
			end
			L_SQR: begin
				// square of the q1.31 mantissa, renormalize when it reaches two
				if (t[32]) begin
					m_q    <= t[32:1];
					frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
				end else begin
					m_q    <= t[31:0];
					frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
				end
				k_q <= k_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/sig_div.sv */
// sig_div: restoring divider, one quotient bit per cycle
// no package dependencies
`default_nettype none

module sig_div #(
	parameter int NW = 64,
	parameter int DW = 38
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient
);

	localparam int IW = $clog2(NW);

	logic          run_q;
	logic          done_q;
	logic [IW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   r2;
	logic          ge;

	assign r2       = {rem_q, quo_q[NW-1]};
	assign ge       = r2 >= {1'b0, den_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == IW'(NW-1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? DW'(r2 - {1'b0, den_q}) : r2[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

endmodule

`default_nettype wire

/* hdl/split_information_gain_core.sv */
// split_information_gain_core: top level, weight tables in ram plus compute sequencer
// depends on sig_pkg, sig_ram, sig_log2, sig_div
// load: a transaction without last does a read-modify-write of the weight ram
// last transaction: per table row the sum and row control plus, for a nonzero sum, its
// log, then per nonzero entry a log (shared log2 unit, 16 squarings) and per zero entry
// a skip; then two divisions, each skipped on a zero denominator, and branch counting;
// done is registered in the output state after that
// after reset a clearing pass over all (NB+1)*NC entries (144 by default) holds busy high
// results are strobed on done for one cycle; there is no back pressure
`default_nettype none

module split_information_gain_core
	import sig_pkg::*;
#(
	parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
	parameter int NUM_BRANCHES = NUM_BRANCHES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire item_t              item,
	output logic                    done,
	output result_t                 result,
	input  wire logic               cfg_wr_en,
	input  wire logic [FRAC_W-1:0]  cfg_wr_data
);

	localparam int NC    = NUM_CLASSES;
	localparam int NB    = NUM_BRANCHES;
	localparam int CW    = $clog2(NC);
	localparam int DEPTH = (NB + 1) * NC;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(NB + 1);
	localparam int BIW   = $clog2(NB);
	localparam int SW    = WEIGHT_W + CW;
	localparam int TW    = SW + $clog2(NB);
	localparam int LW    = $clog2(SW) + FRAC_W;
	localparam int PW    = WEIGHT_W + LW;
	localparam int MDW   = LW + 1;

	localparam logic signed [MDW-1:0] MMAX = MDW'(MERIT_MAX);
	localparam logic signed [MDW-1:0] MMIN = MDW'(MERIT_MIN);

	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_LD   = 5'd2;
	localparam logic [4:0] S_ROW  = 5'd3;
	localparam logic [4:0] S_SRD  = 5'd4;
	localparam logic [4:0] S_SAC  = 5'd5;
	localparam logic [4:0] S_LS   = 5'd6;
	localparam logic [4:0] S_WRD  = 5'd7;
	localparam logic [4:0] S_WCK  = 5'd8;
	localparam logic [4:0] S_WLG  = 5'd9;
	localparam logic [4:0] S_MUL  = 5'd10;
	localparam logic [4:0] S_ACC  = 5'd11;
	localparam logic [4:0] S_REND = 5'd12;
	localparam logic [4:0] S_DIV  = 5'd13;
	localparam logic [4:0] S_DIVW = 5'd14;
	localparam logic [4:0] S_THR  = 5'd15;
	localparam logic [4:0] S_CNT  = 5'd16;
	localparam logic [4:0] S_OUT  = 5'd17;

	logic [4:0]          state_q;
	logic [FRAC_W-1:0]   min_q;
	logic [AW-1:0]       ld_addr_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic                valid_q;
	logic                last_q;
	logic [RW-1:0]       row_q;
	logic [AW-1:0]       base_q;
	logic [CW-1:0]       col_q;
	logic [SW-1:0]       s_q;
	logic [LW-1:0]       ls_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [LW-1:0]       diff_q;
	logic [PW-1:0]       prod_q;
	logic [NUMER_W-1:0]  acc_q;
	logic [NUMER_W-1:0]  bnum_q;
	logic [NUMER_W-1:0]  pnum_q;
	logic [TW-1:0]       wtot_q;
	logic [SW-1:0]       ps_q;
	logic [SW-1:0]       bsum_q [NB];
	logic [LW-1:0]       hp_q;
	logic [LW-1:0]       hb_q;
	logic                dsel_q;
	logic [TW+15:0]      thr_q;
	logic [BIW-1:0]      bi_q;
	logic [CNT_W-1:0]    above_q;
	logic                done_q;
	result_t             result_q;

	logic                accept;
	logic                in_ok;
	logic [AW-1:0]       in_addr;
	logic [AW-1:0]       cur_addr;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	logic [WEIGHT_W-1:0] wdata;
	logic                we;
	logic [WEIGHT_W-1:0] rdata;
	logic [WEIGHT_W:0]   sat_sum;
	logic [SW-1:0]       s_next;
	logic                log_start;
	logic [SW-1:0]       log_x;
	logic                log_done;
	logic [LW-1:0]       log_res;
	logic                div_start;
	logic [TW-1:0]       div_den;
	logic                div_done;
	logic [NUMER_W-1:0]  div_quo;
	logic signed [MDW-1:0] mdiff;
	logic                col_end;

	assign busy     = state_q != S_IDLE;
	assign accept   = start && !busy;
	assign done     = done_q;
	assign result   = result_q;

	assign in_ok = (32'(item.class_index) < 32'(NC)) &&
		(item.mode || (32'(item.branch) < 32'(NB)));
	assign in_addr = item.mode ?
		AW'(32'(NB * NC) + 32'(item.class_index)) :
		AW'(32'(item.branch) * 32'(NC) + 32'(item.class_index));
	assign cur_addr = base_q + AW'(col_q);
	assign raddr    = (state_q == S_IDLE) ? in_addr : cur_addr;
	assign sat_sum  = {1'b0, rdata} + {1'b0, weight_q};
	assign s_next   = s_q + SW'(rdata);
	assign col_end  = col_q == CW'(NC - 1);

	always_comb begin
		we    = 1'b0;
		waddr = ld_addr_q;
		wdata = '0;
		unique case (state_q)
			S_CLR: we = 1'b1;
			S_LD: begin
				we    = valid_q;
				wdata = sat_sum[WEIGHT_W] ? '1 : sat_sum[WEIGHT_W-1:0];
			end
			S_WCK: begin
				// entries are cleared as they are consumed
				we    = 1'b1;
				waddr = cur_addr;
			end
			default: ;
		endcase
	end

	assign log_start = ((state_q == S_SAC) && col_end && (s_next != '0)) ||
		((state_q == S_WCK) && (rdata != '0));
	assign log_x     = (state_q == S_SAC) ? s_next : SW'(rdata);

	assign div_den   = dsel_q ? wtot_q : TW'(ps_q);
	assign div_start = (state_q == S_DIV) && (div_den != '0);

	assign mdiff = $signed({1'b0, hp_q}) - $signed({1'b0, hb_q});

	sig_ram #(
		.WIDTH(WEIGHT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	sig_log2 #(
		.XW(SW)
	) u_log2 (
		.clk   (clk),
		.arst_n(arst_n),
		.start (log_start),
		.x     (log_x),
		.done  (log_done),
		.result(log_res)
	);

	sig_div #(
		.NW(NUMER_W),
		.DW(TW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dsel_q ? bnum_q : pnum_q),
		.divisor (div_den),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_FRAC_RST;
		end else if (cfg_wr_en) begin
			min_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			ld_addr_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					ld_addr_q <= ld_addr_q + 1'b1;
					if (ld_addr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						ld_addr_q <= in_addr;
						state_q   <= S_LD;
					end
				end
				S_LD:   state_q <= last_q ? S_ROW : S_IDLE;
				S_ROW:  state_q <= S_SRD;
				S_SRD:  state_q <= S_SAC;
				S_SAC: begin
					if (col_end) begin
						state_q <= (s_next == '0) ? S_REND : S_LS;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_LS: begin
					if (log_done) begin
						state_q <= S_WRD;
					end
				end
				S_WRD: state_q <= S_WCK;
				S_WCK: begin
					if (rdata != '0) begin
						state_q <= S_WLG;
					end else begin
						state_q <= col_end ? S_REND : S_WRD;
					end
				end
				S_WLG: begin
					if (log_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: state_q <= col_end ? S_REND : S_WRD;
				S_REND: state_q <= (row_q == RW'(NB)) ? S_DIV : S_ROW;
				S_DIV: begin
					if (div_den != '0) begin
						state_q <= S_DIVW;
					end else if (dsel_q) begin
						state_q <= S_THR;
					end
				end
				S_DIVW: begin
					if (div_done) begin
						state_q <= dsel_q ? S_THR : S_DIV;
					end
				end
				S_THR: state_q <= S_CNT;
				S_CNT: begin
					if (bi_q == BIW'(NB - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				weight_q <= item.weight;
				valid_q  <= in_ok;
				last_q   <= item.last;
			end
			S_LD: begin
				row_q  <= '0;
				base_q <= '0;
				bnum_q <= '0;
				wtot_q <= '0;
			end
			S_ROW: begin
				col_q <= '0;
				s_q   <= '0;
				acc_q <= '0;
			end
			S_SAC: begin
				s_q   <= s_next;
				col_q <= col_end ? '0 : col_q + 1'b1;
			end
			S_LS: begin
				if (log_done) begin
					ls_q <= log_res;
				end
			end
			S_WCK: begin
				w_q <= rdata;
				if (rdata == '0 && !col_end) begin
					col_q <= col_q + 1'b1;
				end
			end
			S_WLG: begin
				if (log_done) begin
					diff_q <= (ls_q > log_res) ? ls_q - log_res : '0;
				end
			end
			S_MUL: prod_q <= PW'(w_q) * PW'(diff_q);
			S_ACC: begin
				acc_q <= acc_q + NUMER_W'(prod_q);
				if (!col_end) begin
					col_q <= col_q + 1'b1;
				end
			end
			S_REND: begin
				if (row_q == RW'(NB)) begin
					pnum_q <= acc_q;
					ps_q   <= s_q;
					dsel_q <= 1'b0;
				end else begin
					bnum_q               <= bnum_q + acc_q;
					wtot_q               <= wtot_q + TW'(s_q);
					bsum_q[row_q[BIW-1:0]] <= s_q;
					row_q                <= row_q + 1'b1;
					base_q               <= base_q + AW'(NC);
				end
			end
			S_DIV: begin
				if (div_den == '0) begin
					if (dsel_q) begin
						hb_q <= '0;
					end else begin
						hp_q   <= '0;
						dsel_q <= 1'b1;
					end
				end
			end
			S_DIVW: begin
				if (div_done) begin
					if (dsel_q) begin
						hb_q <= div_quo[LW-1:0];
					end else begin
						hp_q   <= div_quo[LW-1:0];
						dsel_q <= 1'b1;
					end
				end
			end
			S_THR: begin
				thr_q   <= (TW+16)'(min_q) * (TW+16)'(wtot_q);
				bi_q    <= '0;
				above_q <= '0;
			end
			S_CNT: begin
				// share test: bsum * 2^16 > min * total
				if (wtot_q != '0 && (TW+16)'({bsum_q[bi_q], 16'b0}) > thr_q &&
					above_q != CNT_MAX) begin
					above_q <= above_q + 1'b1;
				end
				if (bi_q != BIW'(NB - 1)) begin
					bi_q <= bi_q + 1'b1;
				end
			end
			S_OUT: begin
				if (mdiff > MMAX) begin
					result_q.merit <= MERIT_W'(MMAX);
				end else if (mdiff < MMIN) begin
					result_q.merit <= MERIT_W'(MMIN);
				end else begin
					result_q.merit <= MERIT_W'(mdiff);
				end
				result_q.branches_above <= above_q;
				result_q.empty_branches <= wtot_q == '0;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
